[rtl/rmcq_pkg.sv]
// ----------------------------------------------------------------------------
// rmcq_pkg
// Shared types and constants for the range mode count query block: field
// widths, stream packing, register map and the sequencer states.
// ----------------------------------------------------------------------------
package rmcq_pkg;

  // Item field widths.
  localparam int POS_W   = 11;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 11;
  localparam int LEN_W   = 11;

  // Stream packing: position, value, left, right from bit 0 up, padded to bytes.
  localparam int S_DATA_W = 72;
  localparam int S_USER_W = 1;
  localparam int M_DATA_W = 16;
  localparam int M_USER_W = 1;

  localparam int POS_LSB   = 0;
  localparam int VALUE_LSB = POS_LSB + POS_W;
  localparam int LEFT_LSB  = VALUE_LSB + VALUE_W;
  localparam int RIGHT_LSB = LEFT_LSB + POS_W;

  // Item kinds carried in tuser.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Register map, by word index (paddr[2]).
  localparam int  APB_ADDR_W     = 3;
  localparam logic REG_ARRAY_LEN = 1'b0;

  localparam logic [LEN_W-1:0]   LENGTH_RESET = 11'd1024;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 11'd2047;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_BLK_SET,
    ST_MRG_RD,
    ST_MRG_WR,
    ST_CNT_RD,
    ST_CNT_UPD,
    ST_FINISH
  } state_t;

endpackage

[rtl/range_mode_count_query.sv]
// ----------------------------------------------------------------------------
// range_mode_count_query
// Stores unsigned values at 1-based positions and answers, for a closed range of
// positions, how often its most frequent value occurs.
// ----------------------------------------------------------------------------
// A write item goes from acceptance through the finish state to its result. A
// query over n positions copies the range into a sort buffer, merge sorts it
// bottom up and then counts runs of equal values. With a single comparator
// and a registered read of the sort RAM, every element passes through a read
// state and then a write state in the copy, in each merge pass and in the
// count. A bad range or a bad write position is answered without any copy,
// sort or count. Input is taken only when the sequencer is idle; a finished
// result waits in the output register.
// ----------------------------------------------------------------------------
module range_mode_count_query #(
  parameter int MAX_LENGTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // tdata: position[10:0], value[42:11], left[53:43], right[64:54], zero pad.
  input  logic [rmcq_pkg::S_DATA_W-1:0] s_tdata,
  // tuser: func[0].
  input  logic [rmcq_pkg::S_USER_W-1:0] s_tuser,
  // Result stream.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // tdata: mode_count[10:0], zero pad.
  output logic [rmcq_pkg::M_DATA_W-1:0] m_tdata,
  // tuser: range_error[0].
  output logic [rmcq_pkg::M_USER_W-1:0] m_tuser,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rmcq_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  import rmcq_pkg::*;

  localparam int AW = $clog2(MAX_LENGTH);
  localparam int CW = $clog2(MAX_LENGTH + 1);
  localparam int SORT_DEPTH = 2 * (1 << AW);

  state_t state, state_next;

  logic [LEN_W-1:0]   array_length;
  logic [COUNT_W-1:0] m_count;
  logic               m_err;

  // Sequencer data path.
  logic [AW-1:0]      base;
  logic [CW-1:0]      n;
  logic [CW-1:0]      k, i, j, lo, mid, hi;
  logic [CW:0]        w;
  logic               src;
  logic [CW-1:0]      run, best;
  logic [VALUE_W-1:0] prev;
  logic [COUNT_W-1:0] res_count;
  logic               res_err;

  // Input field views.
  logic               in_func;
  logic [POS_W-1:0]   in_pos, in_left, in_right;
  logic [VALUE_W-1:0] in_value;
  logic [31:0]        pos32, left32, right32, len32, n_calc, base_calc, wr_calc;
  logic               wr_err, qry_err;
  logic               in_fire, out_free, cfg_write;

  // RAM ports.
  logic               vram_we;
  logic [AW-1:0]      vram_waddr, vram_raddr;
  logic [VALUE_W-1:0] vram_q, vram_q_unused;
  logic               sram_we;
  logic [AW:0]        sram_waddr, sram_raddr_a, sram_raddr_b;
  logic [VALUE_W-1:0] sram_wdata, sram_qa, sram_qb;

  // Shared comparator and step values.
  logic [VALUE_W-1:0] cmp_a, cmp_b;
  logic               cmp_lt, cmp_eq;
  logic               take_j;
  logic [CW-1:0]      k_inc;
  logic [CW+1:0]      sum_hi, dbl_w;
  logic [CW:0]        sum_mid;
  logic [CW-1:0]      mid_calc, hi_calc;
  logic [CW-1:0]      run_next, best_next;
  logic [31:0]        best32;
  logic [COUNT_W-1:0] best_sat;

  assign in_func  = s_tuser[0];
  assign in_pos   = s_tdata[POS_LSB +: POS_W];
  assign in_value = s_tdata[VALUE_LSB +: VALUE_W];
  assign in_left  = s_tdata[LEFT_LSB +: POS_W];
  assign in_right = s_tdata[RIGHT_LSB +: POS_W];

  assign pos32   = 32'(in_pos);
  assign left32  = 32'(in_left);
  assign right32 = 32'(in_right);
  assign len32   = (32'(array_length) > 32'(MAX_LENGTH)) ? 32'(MAX_LENGTH)
                                                         : 32'(array_length);

  assign wr_err  = (pos32 == 32'd0) || (pos32 > 32'(MAX_LENGTH));
  assign qry_err = (left32 == 32'd0) || (left32 > right32) || (right32 > len32);

  assign n_calc    = right32 - left32 + 32'd1;
  assign base_calc = left32 - 32'd1;
  assign wr_calc   = pos32 - 32'd1;

  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_write = psel && penable && pwrite && pready;

  // One comparator serves the merge decision and the run detection.
  always_comb begin
    if (state == ST_MRG_WR) begin
      cmp_a = sram_qb;
      cmp_b = sram_qa;
    end else begin
      cmp_a = sram_qa;
      cmp_b = prev;
    end
  end
  assign cmp_lt = cmp_a < cmp_b;
  assign cmp_eq = cmp_a == cmp_b;

  assign k_inc    = k + 1'b1;
  assign sum_mid  = {1'b0, lo} + w;
  assign sum_hi   = {2'b00, lo} + {w, 1'b0};
  assign dbl_w    = {w, 1'b0};
  assign mid_calc = (sum_mid > {1'b0, n}) ? n : sum_mid[CW-1:0];
  assign hi_calc  = (sum_hi > {2'b00, n}) ? n : sum_hi[CW-1:0];

  // Take the right run when the left one is used up or holds the larger value.
  assign take_j = (i >= mid) || ((j < hi) && cmp_lt);

  assign run_next  = ((k != '0) && cmp_eq) ? run + 1'b1 : CW'(1);
  assign best_next = (run_next > best) ? run_next : best;
  assign best32    = 32'(best_next);
  assign best_sat  = (best32 > 32'(COUNT_MAX)) ? COUNT_MAX : best32[COUNT_W-1:0];

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (in_func == FUNC_WRITE || qry_err) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_COPY_RD;
          end
        end
      end
      ST_COPY_RD: state_next = ST_COPY_WR;
      ST_COPY_WR: begin
        if (k_inc == n) begin
          state_next = (n > CW'(1)) ? ST_BLK_SET : ST_CNT_RD;
        end else begin
          state_next = ST_COPY_RD;
        end
      end
      ST_BLK_SET: state_next = ST_MRG_RD;
      ST_MRG_RD:  state_next = ST_MRG_WR;
      ST_MRG_WR: begin
        if (k_inc != hi) begin
          state_next = ST_MRG_RD;
        end else if (hi != n) begin
          state_next = ST_BLK_SET;
        end else if (dbl_w >= {2'b00, n}) begin
          state_next = ST_CNT_RD;
        end else begin
          state_next = ST_BLK_SET;
        end
      end
      ST_CNT_RD:  state_next = ST_CNT_UPD;
      ST_CNT_UPD: state_next = (k_inc == n) ? ST_FINISH : ST_CNT_RD;
      ST_FINISH:  state_next = out_free ? ST_IDLE : ST_FINISH;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Handshake and memory controls.
  always_comb begin
    s_tready     = (state == ST_IDLE);
    vram_we      = (state == ST_IDLE) && s_tvalid && (in_func == FUNC_WRITE) && !wr_err;
    vram_waddr   = wr_calc[AW-1:0];
    vram_raddr   = base + k[AW-1:0];
    sram_we      = (state == ST_COPY_WR) || (state == ST_MRG_WR);
    sram_waddr   = (state == ST_COPY_WR) ? {1'b0, k[AW-1:0]} : {~src, k[AW-1:0]};
    sram_wdata   = (state == ST_COPY_WR) ? vram_q : (take_j ? sram_qb : sram_qa);
    sram_raddr_a = (state == ST_MRG_RD) ? {src, i[AW-1:0]} : {src, k[AW-1:0]};
    sram_raddr_b = {src, j[AW-1:0]};
  end

  rmcq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (1 << AW)
  ) u_value_ram (
    .clk     (clk),
    .we      (vram_we),
    .waddr   (vram_waddr),
    .wdata   (in_value),
    .raddr_a (vram_raddr),
    .rdata_a (vram_q),
    .raddr_b (vram_raddr),
    .rdata_b (vram_q_unused)
  );

  // Two halves of the sort RAM act as ping-pong buffers, selected by src.
  rmcq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (SORT_DEPTH)
  ) u_sort_ram (
    .clk     (clk),
    .we      (sram_we),
    .waddr   (sram_waddr),
    .wdata   (sram_wdata),
    .raddr_a (sram_raddr_a),
    .rdata_a (sram_qa),
    .raddr_b (sram_raddr_b),
    .rdata_b (sram_qb)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      m_tvalid     <= 1'b0;
      array_length <= LENGTH_RESET;
    end else begin
      state <= state_next;
      if (cfg_write && paddr[2] == REG_ARRAY_LEN) begin
        array_length <= pwdata[LEN_W-1:0];
      end
      if (state == ST_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Sequencer data path.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          base      <= base_calc[AW-1:0];
          n         <= n_calc[CW-1:0];
          k         <= '0;
          lo        <= '0;
          w         <= (CW + 1)'(1);
          src       <= 1'b0;
          run       <= '0;
          best      <= '0;
          res_count <= '0;
          res_err   <= (in_func == FUNC_WRITE) ? wr_err : qry_err;
        end
      end
      ST_COPY_WR: begin
        k <= (k_inc == n) ? '0 : k_inc;
      end
      ST_BLK_SET: begin
        mid <= mid_calc;
        hi  <= hi_calc;
        i   <= lo;
        j   <= mid_calc;
        k   <= lo;
      end
      ST_MRG_WR: begin
        if (take_j) begin
          j <= j + 1'b1;
        end else begin
          i <= i + 1'b1;
        end
        k <= k_inc;
        if (k_inc == hi) begin
          if (hi != n) begin
            lo <= hi;
          end else begin
            lo  <= '0;
            w   <= dbl_w[CW:0];
            src <= ~src;
            k   <= '0;
          end
        end
      end
      ST_CNT_UPD: begin
        run  <= run_next;
        best <= best_next;
        prev <= sram_qa;
        k    <= k_inc;
        if (k_inc == n) begin
          res_count <= best_sat;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          m_count <= res_count;
          m_err   <= res_err;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = {{(M_DATA_W - COUNT_W){1'b0}}, m_count};
  assign m_tuser = m_err;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ARRAY_LEN) ? {{(32 - LEN_W){1'b0}}, array_length}
                                              : 32'd0;

  // A merge step always has an element left in one of the two runs.
  a_merge_has_input: assert property (@(posedge clk) disable iff (rst)
    state == ST_MRG_WR |-> (i < mid) || (j < hi))
    else $error("merge step with both runs exhausted");

  // The output slot stays inside the block being merged.
  a_merge_in_block: assert property (@(posedge clk) disable iff (rst)
    state == ST_MRG_WR |-> (k >= lo) && (k < hi))
    else $error("merge output index outside the block");

  // A run of equal values cannot be longer than the elements counted so far.
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_CNT_UPD |=> run <= k)
    else $error("run length exceeds elements counted");

  // An error result never carries a count.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("error result with nonzero count");

  // Input is only taken while no item is in flight in the sequencer.
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !s_tready)
    else $error("input accepted while busy");

endmodule

[rtl/rmcq_ram.sv]
// ----------------------------------------------------------------------------
// rmcq_ram
// Generic RAM: one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module rmcq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
